[design/rebp_pkg.sv]
// ----------------------------------------------------------------------------
// rebp_pkg
// shared constants and controller/datapath handshake types for the rice packer
// ----------------------------------------------------------------------------
package rebp_pkg;

	localparam int MAX_UNARY_DEF = 480;
	localparam int K_W           = 4;
	localparam int RES_W         = 17;
	localparam int BYTE_W        = 8;
	localparam int PART_W        = 7;
	localparam int FILL_W        = 3;

	localparam logic [K_W-1:0] RICE_K_RESET = 4'd4;

	// item modes as carried on the input channel
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic emit;
		logic commit;
	} rebp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic out_free;
	} rebp_sts_t;

endpackage

[design/rebp_in_if.sv]
// ----------------------------------------------------------------------------
// rebp_in_if
// input channel: one residual or flush request per transaction
// ----------------------------------------------------------------------------
interface rebp_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [16:0] residual;

	modport source (output valid, output mode, output residual, input ready);
	modport sink (input valid, input mode, input residual, output ready);
endinterface

[design/rebp_out_if.sv]
// ----------------------------------------------------------------------------
// rebp_out_if
// output channel: one packed code byte per transaction
// ----------------------------------------------------------------------------
interface rebp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       last;
	logic       overflow;

	modport source (output valid, output byte_out, output last, output overflow, input ready);
	modport sink (input valid, input byte_out, input last, input overflow, output ready);
endinterface

[design/rebp_dp.sv]
// ----------------------------------------------------------------------------
// rebp_dp
// datapath: item registers, code byte generator, packing state, output register
// ----------------------------------------------------------------------------
module rebp_dp import rebp_pkg::*; #(
	parameter int MAX_UNARY = MAX_UNARY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [K_W-1:0]          cfg_wdata,
	input  logic                    in_mode,
	input  logic signed [RES_W-1:0] in_residual,
	input  rebp_cmd_t               cmd,
	output rebp_sts_t               sts,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [BYTE_W-1:0]       byte_out,
	output logic                    last,
	output logic                    overflow
);

	localparam int QW   = $clog2(MAX_UNARY + 1);
	localparam int TMAX = MAX_UNARY + 24;
	localparam int TW   = $clog2(TMAX + 1);
	localparam int NW   = $clog2(TMAX / 8 + 1);
	localparam int SW   = TW + 2;

	logic [K_W-1:0]        k_q;
	logic [PART_W-1:0]     partial_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  mode_q;
	logic                  pos_q;
	logic [RES_W-1:0]      mag_q;
	logic [QW-1:0]         quot_q;
	logic [TW-1:0]         len_q;
	logic [FILL_W-1:0]     fill_new_q;
	logic [NW-1:0]         count_q;
	logic signed [SW-1:0]  off_q;
	logic                  ovf_q;
	logic                  valid_q;
	logic [BYTE_W-1:0]     byte_q;
	logic                  last_q;
	logic                  ovf_out_q;

	logic [RES_W-1:0]      mag_in;
	logic [RES_W-1:0]      quot_full;
	logic                  ovf_d;
	logic [TW-1:0]         len_d;
	logic [TW-1:0]         total_d;
	logic [NW-1:0]         count_d;

	logic signed [SW-1:0]  r_v [BYTE_W];
	logic signed [SW-1:0]  sh;
	logic [24:0]           mag_ext;
	logic [24:0]           rem_shift;
	logic [BYTE_W-1:0]     remwin;
	logic [BYTE_W-1:0]     gen;
	logic [BYTE_W-1:0]     part_ext;
	logic [SW-1:0]         len_ext;
	logic [SW-1:0]         quot_ext;

	// magnitude of the incoming residual
	assign mag_in = in_residual[RES_W-1] ? (~in_residual + 1'b1) : in_residual;

	// quotient, code length and byte count of the held item
	assign quot_full = mag_q >> k_q;
	assign ovf_d     = (mode_q == MODE_ENCODE) && (quot_full > RES_W'(MAX_UNARY));
	assign len_d     = (mode_q == MODE_FLUSH) ? '0 :
		(TW'(quot_full[QW-1:0]) + TW'(2) + TW'(k_q));
	assign total_d   = TW'(fill_q) + len_d;

	always_comb begin
		if (mode_q == MODE_FLUSH) begin
			count_d = NW'(fill_q != '0);
		end else if (ovf_d) begin
			count_d = NW'(1);
		end else begin
			count_d = NW'(total_d >> 3);
		end
	end

	// remainder bits aligned to the current byte window
	assign mag_ext   = {mag_q, 8'b0};
	assign quot_ext  = {{(SW-QW){1'b0}}, quot_q};
	assign len_ext   = {{(SW-TW){1'b0}}, len_q};
	assign sh        = off_q - $signed(quot_ext) + $signed(SW'(6));
	assign rem_shift = mag_ext >> sh[4:0];
	assign remwin    = (sh < 0 || sh > $signed(SW'(24))) ? '0 : rem_shift[BYTE_W-1:0];
	assign part_ext  = {1'b0, partial_q};

	// one byte of the pending-plus-code stream, stream bits past the end read zero
	always_comb begin
		for (int b = 0; b < BYTE_W; b++) begin
			r_v[b] = off_q + $signed(SW'(b));
			if (r_v[b] < 0) begin
				gen[b] = part_ext[b];
			end else if (r_v[b] >= $signed(len_ext)) begin
				gen[b] = 1'b0;
			end else if (r_v[b] == '0) begin
				gen[b] = pos_q;
			end else if (r_v[b] <= $signed(quot_ext)) begin
				gen[b] = 1'b1;
			end else if (r_v[b] == $signed(quot_ext) + $signed(SW'(1))) begin
				gen[b] = 1'b0;
			end else begin
				gen[b] = remwin[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= RICE_K_RESET;
			partial_q <= '0;
			fill_q    <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (mode_q == MODE_FLUSH) begin
					partial_q <= '0;
					fill_q    <= '0;
				end else if (!ovf_q) begin
					partial_q <= gen[PART_W-1:0];
					fill_q    <= fill_new_q;
				end
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			pos_q  <= !in_residual[RES_W-1] && (in_residual != '0);
			mag_q  <= mag_in;
		end
		if (cmd.prep) begin
			quot_q     <= quot_full[QW-1:0];
			len_q      <= len_d;
			fill_new_q <= total_d[FILL_W-1:0];
			count_q    <= count_d;
			ovf_q      <= ovf_d;
			off_q      <= -$signed({{(SW-FILL_W){1'b0}}, fill_q});
		end
		if (cmd.emit) begin
			byte_q    <= ovf_q ? '0 : gen;
			last_q    <= (count_q == NW'(1));
			ovf_out_q <= ovf_q;
			count_q   <= count_q - 1'b1;
			off_q     <= off_q + $signed(SW'(BYTE_W));
		end
	end

	assign sts.cnt_zero = (count_q == '0);
	assign sts.out_free = !valid_q || out_ready;

	assign out_valid = valid_q;
	assign byte_out  = byte_q;
	assign last      = last_q;
	assign overflow  = ovf_out_q;

endmodule

[design/rebp_ctrl.sv]
// ----------------------------------------------------------------------------
// rebp_ctrl
// controller: sequences one item through prepare, byte emission and commit
// ----------------------------------------------------------------------------
module rebp_ctrl import rebp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rebp_sts_t sts,
	output rebp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EMIT,
		ST_COMMIT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.prep   = (state_q == ST_PREP);
	assign cmd.emit   = (state_q == ST_EMIT) && !sts.cnt_zero && sts.out_free;
	assign cmd.commit = (state_q == ST_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.cnt_zero) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/rice_encoder_bit_packer.sv]
// ----------------------------------------------------------------------------
// rice_encoder_bit_packer
// sign-magnitude rice coder (divisor 2^k) packing code bits lsb first into bytes
// ----------------------------------------------------------------------------
// first byte: registered in the emit state, after the prepare state that follows the input
// input: held off while an item emits its N results (0 to 63), until its commit step;
//   one byte per cycle from the byte generator, longer on back-pressure
// reset: arst_n clears pending bits and fill count, sets k to 4, drops output valid
// ----------------------------------------------------------------------------
module rice_encoder_bit_packer import rebp_pkg::*; #(
	parameter int MAX_UNARY = MAX_UNARY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [K_W-1:0] cfg_wdata,
	rebp_in_if.sink        item,
	rebp_out_if.source     result
);

	// command and status bundles between controller and datapath
	rebp_cmd_t cmd;
	rebp_sts_t sts;

	// controller: one item at a time, input held off until the commit step
	rebp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: k register, packing state, byte generator and output register
	rebp_dp #(
		.MAX_UNARY (MAX_UNARY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_mode     (item.mode),
		.in_residual (item.residual),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.byte_out    (result.byte_out),
		.last        (result.last),
		.overflow    (result.overflow)
	);

	// input is refused in the cycle after a transaction while the item is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input accepted while an item is in progress");

	// an overflow result is always the only and final byte of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.overflow) |-> (result.last && result.byte_out == '0))
		else $error("overflow result not marked last or not zero");

	// a byte is never emitted past the computed count
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.cnt_zero)
		else $error("byte emitted with no bytes left");

	// commit only follows a drained byte count
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(sts.cnt_zero))
		else $error("commit before all bytes emitted");

endmodule

[tb/sv/rice_encoder_bit_packer_tb.sv]
// ----------------------------------------------------------------------------
// rice_encoder_bit_packer_tb
// self-checking bench: residual and flush transactions go through a queued
// driver, and an in-bench rice coder predicts every packed byte. A monitor
// compares each output transaction against the oldest predicted byte. Both
// channels idle and stall at random, and k is swept between phases.
// ----------------------------------------------------------------------------
module rice_encoder_bit_packer_tb import rebp_pkg::*;;

	// quiet cycles (nothing accepted on either side) before the run is abandoned
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// idle cycles after the last expected byte, covering items that emit nothing
	localparam int unsigned SETTLE_CYCLES  = 12;
	localparam int unsigned ITEMS_PER_PHASE = 12;

	typedef struct {
		logic               mode;
		logic signed [16:0] residual;
	} rice_item_t;

	typedef struct {
		logic [7:0] code_byte;
		logic       last;
		logic       overflow;
	} code_byte_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block inputs, all known from time zero
	logic               cfg_we      = 1'b0;
	logic [K_W-1:0]     cfg_wdata   = RICE_K_RESET;
	logic               in_valid    = 1'b0;
	logic               in_mode     = MODE_ENCODE;
	logic signed [16:0] in_residual = '0;
	logic               out_ready   = 1'b0;

	rebp_in_if  item_ch ();
	rebp_out_if result_ch ();

	assign item_ch.valid    = in_valid;
	assign item_ch.mode     = in_mode;
	assign item_ch.residual = in_residual;
	assign result_ch.ready  = out_ready;

	rice_encoder_bit_packer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// items waiting to be driven, and bytes the coder has yet to deliver
	rice_item_t stim_fifo[$];
	code_byte_t code_bytes_due[$];

	// predicted coder state: pending bits (first in bit 0), their count, and k
	logic [6:0]     pend_bits  = '0;
	logic [2:0]     pend_count = '0;
	logic [K_W-1:0] coder_k    = RICE_K_RESET;

	int unsigned items_sent       = 0;
	int unsigned bytes_checked    = 0;
	int unsigned overflows_seen   = 0;
	int unsigned mismatches       = 0;
	int unsigned k_settings       = 1;
	int unsigned idle_cycles      = 0;

	// idling state of the two sides
	int unsigned in_gap    = 0;
	int unsigned in_calm   = 0;
	int unsigned out_stall = 0;
	int unsigned out_calm  = 0;
	rice_item_t  next_item;

	// mostly short gaps, some long ones, and now and then a run with none at all
	function automatic int unsigned draw_gap(inout int unsigned calm);
		int unsigned roll;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// append one code bit; a full byte becomes an expected transaction
	function automatic void pack_bit(input logic b);
		logic [7:0] full;
		full = {1'b0, pend_bits} | ({7'd0, b} << pend_count);
		if (pend_count == 3'd7) begin
			code_bytes_due.push_back('{code_byte: full, last: 1'b0, overflow: 1'b0});
			pend_bits  = '0;
			pend_count = '0;
		end else begin
			pend_bits  = full[6:0];
			pend_count = pend_count + 3'd1;
		end
	endfunction

	// rice-code one accepted item and queue the bytes it completes
	function automatic void predict_codes(input logic mode, input logic signed [16:0] residual);
		int          first_new;
		int          value;
		int unsigned mag;
		int unsigned quot;
		code_byte_t  tail;
		first_new = code_bytes_due.size();
		if (mode == MODE_FLUSH) begin
			// residual ignored; pending bits go out zero padded
			if (pend_count != 3'd0) begin
				code_bytes_due.push_back('{code_byte: {1'b0, pend_bits}, last: 1'b0,
					overflow: 1'b0});
				pend_bits  = '0;
				pend_count = '0;
			end
		end else begin
			value = int'(residual);
			mag   = (value < 0) ? -value : value;
			quot  = mag >> coder_k;
			if (quot > MAX_UNARY_DEF) begin
				// nothing encoded, state untouched
				code_bytes_due.push_back('{code_byte: 8'd0, last: 1'b0, overflow: 1'b1});
			end else begin
				pack_bit(value > 0);
				for (int i = 0; i < quot; i++)
					pack_bit(1'b1);
				pack_bit(1'b0);
				for (int i = 0; i < coder_k; i++)
					pack_bit(mag[i]);
			end
		end
		if (code_bytes_due.size() > first_new) begin
			tail      = code_bytes_due.pop_back();
			tail.last = 1'b1;
			code_bytes_due.push_back(tail);
		end
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// driver: presents queued items, holds them until accepted, idles between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			in_mode     <= MODE_ENCODE;
			in_residual <= '0;
			in_gap      = 0;
		end else if (!in_valid || item_ch.ready) begin
			// a transaction completes at this edge: predict what it produces
			if (in_valid) begin
				predict_codes(in_mode, in_residual);
				items_sent++;
			end
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (stim_fifo.size() != 0) begin
				next_item = stim_fifo.pop_front();
				in_valid    <= 1'b1;
				in_mode     <= next_item.mode;
				in_residual <= next_item.residual;
				in_gap      = draw_gap(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each output transaction, stalls the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_ready && result_ch.valid) begin
				if (code_bytes_due.size() == 0) begin
					$display("%0t: unexpected byte, expected none, actual 0x%02h last %b overflow %b",
						$time, result_ch.byte_out, result_ch.last, result_ch.overflow);
					mismatches++;
				end else begin
					check_field("byte_out", code_bytes_due[0].code_byte, result_ch.byte_out);
					check_field("last", {7'd0, code_bytes_due[0].last}, {7'd0, result_ch.last});
					check_field("overflow", {7'd0, code_bytes_due[0].overflow},
						{7'd0, result_ch.overflow});
					if (code_bytes_due[0].overflow)
						overflows_seen++;
					void'(code_bytes_due.pop_front());
					bytes_checked++;
				end
			end
			if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall = draw_gap(out_calm);
				out_ready <= (out_stall == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles where neither channel moves a transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && item_ch.ready) || (out_ready && result_ch.valid))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d bytes still due", $time,
					WATCHDOG_LIMIT, code_bytes_due.size());
				$display("rice_encoder_bit_packer verification failed");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic mode, input int residual);
		stim_fifo.push_back('{mode: mode, residual: 17'(residual)});
	endtask

	// sampled on the falling edge so the driver's updates at the rising edge have settled
	task automatic wait_until_drained();
		while (stim_fifo.size() != 0 || in_valid || code_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// k only changes while the coder is idle
	task automatic write_rice_k(input int unsigned k);
		wait_until_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= K_W'(k);
		coder_k   = K_W'(k);
		@(posedge clk);
		cfg_we <= 1'b0;
		k_settings++;
	endtask

	// random item: mostly small quotients, some near the unary limit,
	// some raw 17-bit values, and a few flushes
	task automatic queue_random_item();
		int unsigned roll;
		int unsigned quot;
		int          mag;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			queue_item(MODE_FLUSH, int'($urandom));
		end else if (roll < 22) begin
			queue_item(MODE_ENCODE, int'($urandom));
		end else begin
			if (roll < 32)
				quot = $urandom_range(MAX_UNARY_DEF - 2, MAX_UNARY_DEF + 2);
			else
				quot = $urandom_range(0, (roll < 70) ? 3 : 24);
			mag = (quot << coder_k) | $urandom_range(0, (1 << coder_k) - 1);
			if (mag > 65535)
				mag = 65535;
			queue_item(MODE_ENCODE, $urandom_range(0, 1) ? -mag : mag);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, k at its reset value of 4
		queue_item(MODE_ENCODE, 0);           // zero residual, bits left pending
		queue_item(MODE_FLUSH, 0);            // flush with pending bits
		queue_item(MODE_FLUSH, 0);            // flush with nothing pending
		queue_item(MODE_ENCODE, 1);
		queue_item(MODE_ENCODE, -1);
		queue_item(MODE_ENCODE, 7695);        // quotient exactly at the unary limit
		queue_item(MODE_ENCODE, -7695);
		queue_item(MODE_ENCODE, 7696);        // just over the limit
		queue_item(MODE_ENCODE, 65535);
		queue_item(MODE_ENCODE, -65536);
		queue_item(MODE_FLUSH, -12345);       // residual field ignored on flush
		queue_item(MODE_ENCODE, 15);
		queue_item(MODE_ENCODE, -16);
		queue_item(MODE_FLUSH, 0);

		// smallest k: the quotient is the whole magnitude
		write_rice_k(0);
		queue_item(MODE_ENCODE, 480);
		queue_item(MODE_ENCODE, -480);
		queue_item(MODE_ENCODE, 481);
		queue_item(MODE_ENCODE, -481);
		queue_item(MODE_ENCODE, 0);
		queue_item(MODE_FLUSH, 0);

		// k of 15, above the nominal range: widest remainder
		write_rice_k(15);
		queue_item(MODE_ENCODE, 65535);
		queue_item(MODE_ENCODE, -65536);
		queue_item(MODE_ENCODE, 0);
		queue_item(MODE_ENCODE, 32768);
		queue_item(MODE_FLUSH, 0);

		// random phases, pending bits carried across each k change
		write_rice_k(14);
		repeat (ITEMS_PER_PHASE) queue_random_item();
		write_rice_k(0);
		repeat (ITEMS_PER_PHASE) queue_random_item();
		write_rice_k(15);
		repeat (ITEMS_PER_PHASE) queue_random_item();
		repeat (4) begin
			write_rice_k($urandom_range(0, 15));
			repeat (ITEMS_PER_PHASE) queue_random_item();
		end

		wait_until_drained();
		repeat (20) @(negedge clk);

		$display("sent %0d residual and flush transactions over %0d settings of k",
			items_sent, k_settings);
		$display("checked %0d code bytes, %0d of them overflow flags, %0d mismatches",
			bytes_checked, overflows_seen, mismatches);
		if (mismatches == 0 && code_bytes_due.size() == 0) begin
			$display("rice_encoder_bit_packer verification clean");
		end else begin
			$display("rice_encoder_bit_packer verification failed");
		end
		$finish;
	end

endmodule
